// File: hdl/pmd_pkg.sv
// Shared types and constants for the dense Prim minimum spanning tree block.
// Used by pmd_cell, prim_mst_dense_top and the testbench; no dependencies of its own.
`timescale 1ns / 1ps

package pmd_pkg;

	localparam int MAX_V       = 32;
	localparam int VIDX_W      = $clog2(MAX_V);
	localparam int VCNT_W      = $clog2(MAX_V + 1);
	localparam int WEIGHT_BITS = 16;
	localparam int KEY_W       = WEIGHT_BITS + 1;
	localparam int ADJ_DEPTH   = MAX_V * MAX_V;
	localparam int ADDR_W      = $clog2(ADJ_DEPTH);

	localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};

	// Input item kinds.
	localparam logic [1:0] FUNC_CLEAR = 2'd0;
	localparam logic [1:0] FUNC_ADD   = 2'd1;
	localparam logic [1:0] FUNC_SOLVE = 2'd2;

	// Control broadcast from the sequencer to every cell.
	typedef struct packed {
		logic                   init;
		logic                   relax;
		logic                   take;
		logic [VIDX_W-1:0]      idx;
		logic [VIDX_W-1:0]      u;
		logic [WEIGHT_BITS-1:0] w;
	} cell_ctrl_t;

	// Running minimum handed from cell to cell.
	typedef struct packed {
		logic              found;
		logic [KEY_W-1:0]  key;
		logic [VIDX_W-1:0] idx;
	} min_t;

endpackage

// File: hdl/pmd_ram.sv
// Generic single write port RAM with one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module pmd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: hdl/pmd_cell.sv
// One vertex cell: holds in-tree flag, key and parent, relaxes its key and
// forwards the running minimum to its neighbor. Depends on pmd_pkg.
`timescale 1ns / 1ps

module pmd_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [pmd_pkg::VIDX_W-1:0]    my_idx,
	input  logic                          active,
	input  pmd_pkg::cell_ctrl_t           ctrl,
	input  pmd_pkg::min_t                 min_in,
	output pmd_pkg::min_t                 min_out,
	output logic [pmd_pkg::KEY_W-1:0]     key,
	output logic [pmd_pkg::VIDX_W-1:0]    parent
);

	logic                       in_tree_q;
	logic [pmd_pkg::KEY_W-1:0]  key_q;
	logic [pmd_pkg::VIDX_W-1:0] parent_q;
	pmd_pkg::min_t              min_q;
	logic                       hit;
	logic [pmd_pkg::KEY_W-1:0]  w_ext;

	assign hit   = (ctrl.idx == my_idx);
	assign w_ext = {1'b0, ctrl.w};

	// Vertex state: initialize, mark as taken, or relax.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_tree_q <= 1'b0;
			key_q     <= pmd_pkg::KEY_MAX;
			parent_q  <= '0;
		end else if (ctrl.init) begin
			in_tree_q <= 1'b0;
			key_q     <= (my_idx == '0) ? '0 : pmd_pkg::KEY_MAX;
			parent_q  <= '0;
		end else begin
			if (ctrl.take && hit) begin
				in_tree_q <= 1'b1;
			end
			if (ctrl.relax && hit && ctrl.w != '0 && !in_tree_q && key_q > w_ext) begin
				key_q    <= w_ext;
				parent_q <= ctrl.u;
			end
		end
	end

	// Minimum chain: take over only on a strictly smaller key.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= '0;
		end else if (active && !in_tree_q && (!min_in.found || min_in.key > key_q)) begin
			min_q <= '{found: 1'b1, key: key_q, idx: my_idx};
		end else begin
			min_q <= min_in;
		end
	end

	assign min_out = min_q;
	assign key     = key_q;
	assign parent  = parent_q;

	// A vertex leaves the tree only through a new solve.
	a_tree_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_tree_q) |-> $past(ctrl.init))
		else $error("in-tree flag cleared without init");

endmodule

// File: hdl/prim_mst_dense_top.sv
// Channel  | Signals                         | Contents
// input    | s_tvalid s_tready s_tdata s_tuser | edge and function per transfer
// output   | m_tvalid m_tready m_tdata m_tuser m_tlast | one tree edge per transfer
// config   | cfg_we cfg_wdata                | vertex count
//
// Clear writes all 1024 adjacency words, one per cycle; the same sweep runs after reset.
// Add edge makes two writes, one per direction, to the single-write-port adjacency RAM.
// Solve runs n rounds, each a pass of the minimum through the cell chain plus
// an adjacency row sweep; then n-1 result transfers.
// One item is in work at a time; output stalls hold the result register.
// Top level: sequencer, adjacency RAM and cell chain. Depends on pmd_pkg, pmd_ram, pmd_cell.
`timescale 1ns / 1ps

module prim_mst_dense_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // end_a[4:0], end_b[9:5], edge_weight[25:10], zeros
	input  logic [1:0]  s_tuser,   // func[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // low_vertex[4:0], high_vertex[9:5], tree_weight[25:10], zeros
	output logic        m_tuser,   // reached[0]
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [5:0]  cfg_wdata
);

	localparam logic [2:0] ST_CLR   = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_ADD2  = 3'd2;
	localparam logic [2:0] ST_MINW  = 3'd3;
	localparam logic [2:0] ST_RELAX = 3'd4;
	localparam logic [2:0] ST_EMIT  = 3'd5;

	localparam int VI = pmd_pkg::VIDX_W;
	localparam int VC = pmd_pkg::VCNT_W;
	localparam int AW = pmd_pkg::ADDR_W;
	localparam int WB = pmd_pkg::WEIGHT_BITS;

	logic [2:0]    st_q;
	logic [AW-1:0] clr_q;
	logic [5:0]    vcnt_q;
	logic [VC-1:0] n_q;
	logic [VC-1:0] wcnt_q;
	logic [VC-1:0] j_q;
	logic [VC-1:0] rnd_q;
	logic [VI-1:0] u_q;
	logic [VI-1:0] v_q;
	logic          rd_v_s1;
	logic [VI-1:0] j_s1;
	logic [AW-1:0] add2_addr_q;
	logic [WB-1:0] add2_w_q;

	logic          out_v_q;
	logic [31:0]   out_data_q;
	logic          out_reached_q;
	logic          out_last_q;

	logic          acc;
	logic [1:0]    func;
	logic [VI-1:0] end_a;
	logic [VI-1:0] end_b;
	logic [WB-1:0] edge_weight;
	logic [VC-1:0] n_new;
	logic          edge_ok;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [WB-1:0] ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [WB-1:0] ram_rdata;

	pmd_pkg::cell_ctrl_t        ctrl;
	pmd_pkg::min_t              chain [pmd_pkg::MAX_V+1];
	logic [pmd_pkg::KEY_W-1:0]  keys [pmd_pkg::MAX_V];
	logic [VI-1:0]              parents [pmd_pkg::MAX_V];

	logic          emit_load;
	logic          out_free;
	logic [VI-1:0] par_v;
	logic [VI-1:0] lo_v;
	logic [VI-1:0] hi_v;
	logic          reach_v;

	// Input field unpacking.
	assign func        = s_tuser;
	assign end_a       = s_tdata[4:0];
	assign end_b       = s_tdata[9:5];
	assign edge_weight = s_tdata[25:10];
	assign s_tready    = (st_q == ST_IDLE);
	assign acc         = s_tvalid && s_tready;
	assign edge_ok     = ({1'b0, end_a} < VC'(pmd_pkg::MAX_V))
	                  && ({1'b0, end_b} < VC'(pmd_pkg::MAX_V));

	// Active vertex count, clamped to 1..MAX_V.
	always_comb begin
		if (vcnt_q == '0) begin
			n_new = VC'(1);
		end else if (vcnt_q > 6'(pmd_pkg::MAX_V)) begin
			n_new = VC'(pmd_pkg::MAX_V);
		end else begin
			n_new = VC'(vcnt_q);
		end
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcnt_q <= 6'd32;
		end else if (cfg_we) begin
			vcnt_q <= cfg_wdata;
		end
	end

	// Adjacency write port: clear sweep, or the two halves of an edge.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = clr_q;
		ram_wdata = '0;
		case (st_q)
			ST_CLR: begin
				ram_we = 1'b1;
			end
			ST_IDLE: begin
				ram_we    = acc && func == pmd_pkg::FUNC_ADD && edge_ok;
				ram_waddr = {end_a, end_b};
				ram_wdata = edge_weight;
			end
			ST_ADD2: begin
				ram_we    = 1'b1;
				ram_waddr = add2_addr_q;
				ram_wdata = add2_w_q;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	assign ram_raddr = {j_q[VI-1:0], u_q};

	pmd_ram #(.WIDTH(WB), .DEPTH(pmd_pkg::ADJ_DEPTH)) u_adj (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Broadcast control to the cells.
	always_comb begin
		ctrl.init  = acc && func == pmd_pkg::FUNC_SOLVE;
		ctrl.take  = (st_q == ST_MINW) && wcnt_q == VC'(pmd_pkg::MAX_V + 1);
		ctrl.relax = (st_q == ST_RELAX) && rd_v_s1;
		ctrl.idx   = ctrl.take ? chain[pmd_pkg::MAX_V].idx : j_s1;
		ctrl.u     = u_q;
		ctrl.w     = ram_rdata;
	end

	assign chain[0] = '0;

	// Row of vertex cells.
	for (genvar g = 0; g < pmd_pkg::MAX_V; g++) begin : g_cell
		pmd_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.my_idx  (VI'(g)),
			.active  (VC'(g) < n_q),
			.ctrl    (ctrl),
			.min_in  (chain[g]),
			.min_out (chain[g+1]),
			.key     (keys[g]),
			.parent  (parents[g])
		);
	end

	// Result for the vertex being emitted.
	assign par_v    = parents[v_q];
	assign reach_v  = keys[v_q] != pmd_pkg::KEY_MAX;
	assign lo_v     = !reach_v ? '0 : ((par_v < v_q) ? par_v : v_q);
	assign hi_v     = !reach_v ? v_q : ((par_v < v_q) ? v_q : par_v);
	assign out_free = !out_v_q || m_tready;
	assign emit_load = (st_q == ST_EMIT) && out_free;

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_CLR;
			clr_q   <= '0;
			n_q     <= VC'(pmd_pkg::MAX_V);
			wcnt_q  <= '0;
			j_q     <= '0;
			rnd_q   <= '0;
			u_q     <= '0;
			v_q     <= '0;
			rd_v_s1 <= 1'b0;
			j_s1    <= '0;
		end else begin
			case (st_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(pmd_pkg::ADJ_DEPTH - 1)) begin
						st_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (acc) begin
						case (func)
							pmd_pkg::FUNC_CLEAR: begin
								st_q  <= ST_CLR;
								clr_q <= '0;
							end
							pmd_pkg::FUNC_ADD: begin
								if (edge_ok) begin
									st_q <= ST_ADD2;
								end
							end
							pmd_pkg::FUNC_SOLVE: begin
								st_q   <= ST_MINW;
								n_q    <= n_new;
								wcnt_q <= '0;
								rnd_q  <= '0;
							end
							default: begin
								st_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_ADD2: begin
					st_q <= ST_IDLE;
				end
				ST_MINW: begin
					wcnt_q <= wcnt_q + 1'b1;
					if (ctrl.take) begin
						u_q     <= chain[pmd_pkg::MAX_V].idx;
						j_q     <= '0;
						rd_v_s1 <= 1'b0;
						st_q    <= ST_RELAX;
					end
				end
				ST_RELAX: begin
					if (j_q < n_q) begin
						rd_v_s1 <= 1'b1;
						j_s1    <= j_q[VI-1:0];
						j_q     <= j_q + 1'b1;
					end else begin
						rd_v_s1 <= 1'b0;
						if (!rd_v_s1) begin
							rnd_q  <= rnd_q + 1'b1;
							wcnt_q <= '0;
							if (rnd_q + 1'b1 == n_q) begin
								v_q  <= VI'(1);
								st_q <= (n_q == VC'(1)) ? ST_IDLE : ST_EMIT;
							end else begin
								st_q <= ST_MINW;
							end
						end
					end
				end
				ST_EMIT: begin
					if (emit_load) begin
						v_q <= v_q + 1'b1;
						if ({1'b0, v_q} == n_q - 1'b1) begin
							st_q <= ST_IDLE;
						end
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Second half of an edge write.
	always_ff @(posedge clk) begin
		if (acc) begin
			add2_addr_q <= {end_b, end_a};
			add2_w_q    <= edge_weight;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (emit_load) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			out_data_q    <= {6'd0, reach_v ? keys[v_q][WB-1:0] : WB'(0), hi_v, lo_v};
			out_reached_q <= reach_v;
			out_last_q    <= ({1'b0, v_q} == n_q - 1'b1);
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_reached_q;
	assign m_tlast  = out_last_q;

	// No input is taken during a clear sweep.
	a_clr_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_CLR) |-> !s_tready)
		else $error("input ready during clear sweep");

	// Results appear only from the emit phase.
	a_emit_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_v_q) |-> $past(st_q == ST_EMIT))
		else $error("result raised outside emit");

	// Adjacency is never written while a solve is running.
	a_no_wr_solve: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_MINW || st_q == ST_RELAX || st_q == ST_EMIT) |-> !ram_we)
		else $error("adjacency write during solve");

endmodule

// File: tb/prim_mst_dense_top_tb.sv
// Testbench for prim_mst_dense_top: edge loads, clears and solves are streamed in and
// each tree edge that comes out is checked against a local Prim's predictor.
// Depends on pmd_pkg and the RTL of prim_mst_dense_top.
`timescale 1ns / 1ps

module prim_mst_dense_top_tb;

	localparam int IDLE_LIMIT  = 60000;
	localparam int CLEAR_WAIT  = 1200;
	localparam logic [1:0] FUNC_NOP = 2'd3;

	typedef struct packed {
		logic [4:0]  lo_v;
		logic [4:0]  hi_v;
		logic [15:0] wt;
		logic        reached;
		logic        last;
	} tree_edge_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;
	logic        cfg_we;
	logic [5:0]  cfg_wdata;

	// Predictor state: adjacency matrix and the vertex count register.
	logic [15:0] graph_w [32][32];
	logic [5:0]  vcount;
	tree_edge_t  tree_q[$];
	int          mismatches;
	int          idle_cycles;
	int          burst_left;

	prim_mst_dense_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Prim's method from vertex 0, pushing one expected tree edge per vertex 1..n-1.
	task automatic predict_tree();
		int          n;
		int          pick;
		bit          found;
		bit          done [32];
		logic [16:0] key [32];
		logic [4:0]  parent [32];
		tree_edge_t  e;
		n = (vcount == 0) ? 1 : ((vcount > 32) ? 32 : int'(vcount));
		for (int i = 0; i < 32; i++) begin
			done[i] = 1'b0;
			key[i] = pmd_pkg::KEY_MAX;
			parent[i] = '0;
		end
		key[0] = '0;
		for (int r = 0; r < n; r++) begin
			pick = 0;
			found = 1'b0;
			for (int i = 0; i < n; i++)
				if (!done[i] && (!found || key[pick] > key[i])) begin
					pick = i;
					found = 1'b1;
				end
			done[pick] = 1'b1;
			for (int j = 0; j < n; j++)
				if (graph_w[j][pick] != 0 && !done[j] && key[j] > {1'b0, graph_w[j][pick]}) begin
					key[j] = {1'b0, graph_w[j][pick]};
					parent[j] = pick[4:0];
				end
		end
		for (int v = 1; v < n; v++) begin
			if (key[v] == pmd_pkg::KEY_MAX) begin
				e.lo_v = '0;
				e.hi_v = v[4:0];
				e.wt = '0;
				e.reached = 1'b0;
			end else begin
				e.lo_v = (parent[v] < v) ? parent[v] : v[4:0];
				e.hi_v = (parent[v] < v) ? v[4:0] : parent[v];
				e.wt = key[v][15:0];
				e.reached = 1'b1;
			end
			e.last = (v == n - 1);
			tree_q.push_back(e);
		end
	endtask

	// Send one item, update the predictor on acceptance, then maybe open a gap.
	task automatic send_item(input logic [1:0] func, input logic [4:0] a,
			input logic [4:0] b, input logic [15:0] w);
		int gap;
		s_tvalid <= 1'b1;
		s_tuser <= func;
		s_tdata <= {6'd0, w, b, a};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		case (func)
			pmd_pkg::FUNC_CLEAR: begin
				foreach (graph_w[i, j])
					graph_w[i][j] = '0;
			end
			pmd_pkg::FUNC_ADD: begin
				graph_w[a][b] = w;
				graph_w[b][a] = w;
			end
			pmd_pkg::FUNC_SOLVE: begin
				predict_tree();
			end
			default: ;
		endcase
		@(negedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(12);
			gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
	endtask

	// Hold off until every expected tree edge is out, then let a clear finish.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (tree_q.size() != 0)
			@(negedge clk);
		repeat (CLEAR_WAIT) @(negedge clk);
	endtask

	task automatic write_vcount(input logic [5:0] value);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		vcount = value;
	endtask

	// Extremes of the fields, every function code and the named corner cases.
	task automatic test_directed();
		send_item(pmd_pkg::FUNC_SOLVE, 5'd0, 5'd0, 16'd0);
		send_item(pmd_pkg::FUNC_ADD, 5'd0, 5'd1, 16'hFFFF);
		send_item(pmd_pkg::FUNC_ADD, 5'd31, 5'd0, 16'd1);
		send_item(pmd_pkg::FUNC_ADD, 5'd2, 5'd2, 16'd5);
		send_item(pmd_pkg::FUNC_ADD, 5'd1, 5'd2, 16'd7);
		send_item(pmd_pkg::FUNC_ADD, 5'd3, 5'd0, 16'd7);
		send_item(pmd_pkg::FUNC_ADD, 5'd31, 5'd31, 16'hFFFF);
		send_item(FUNC_NOP, 5'd31, 5'd31, 16'hFFFF);
		send_item(pmd_pkg::FUNC_SOLVE, 5'd0, 5'd0, 16'd0);
		write_vcount(6'd4);
		send_item(pmd_pkg::FUNC_SOLVE, 5'd0, 5'd0, 16'd0);
		send_item(pmd_pkg::FUNC_ADD, 5'd0, 5'd3, 16'd0);
		send_item(pmd_pkg::FUNC_SOLVE, 5'd0, 5'd0, 16'd0);
		send_item(pmd_pkg::FUNC_CLEAR, 5'd0, 5'd0, 16'd0);
		send_item(pmd_pkg::FUNC_SOLVE, 5'd0, 5'd0, 16'd0);
	endtask

	// Out-of-range and minimum vertex counts.
	task automatic test_vcount_extremes();
		write_vcount(6'd0);
		send_item(pmd_pkg::FUNC_ADD, 5'd0, 5'd1, 16'd3);
		send_item(pmd_pkg::FUNC_SOLVE, 5'd0, 5'd0, 16'd0);
		write_vcount(6'd1);
		send_item(pmd_pkg::FUNC_SOLVE, 5'd0, 5'd0, 16'd0);
		write_vcount(6'd63);
		send_item(pmd_pkg::FUNC_SOLVE, 5'd0, 5'd0, 16'd0);
		write_vcount(6'd2);
		send_item(pmd_pkg::FUNC_SOLVE, 5'd0, 5'd0, 16'd0);
	endtask

	// Random edge loads followed by solves, with some clears and unused codes.
	task automatic test_random(input logic [5:0] count, input int items);
		int          n;
		int          pick;
		logic [4:0]  a;
		logic [4:0]  b;
		logic [15:0] w;
		write_vcount(count);
		n = (count == 0) ? 1 : ((count > 32) ? 32 : int'(count));
		for (int k = 0; k < items; k++) begin
			pick = $urandom_range(99);
			a = ($urandom_range(9) == 0) ? 5'($urandom) : 5'($urandom_range(n));
			b = ($urandom_range(9) == 0) ? 5'($urandom) : 5'($urandom_range(n));
			case ($urandom_range(3))
				0: w = 16'($urandom);
				1: w = 16'($urandom_range(4));
				default: w = 16'($urandom_range(40));
			endcase
			if (pick < 78)
				send_item(pmd_pkg::FUNC_ADD, a, b, w);
			else if (pick < 93)
				send_item(pmd_pkg::FUNC_SOLVE, a, b, w);
			else if (pick < 96)
				send_item(pmd_pkg::FUNC_CLEAR, a, b, w);
			else
				send_item(FUNC_NOP, a, b, w);
		end
		send_item(pmd_pkg::FUNC_SOLVE, 5'd0, 5'd0, 16'd0);
	endtask

	// Receiver: stalls in runs, with long stretches of full throughput.
	always @(negedge clk) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else if ($urandom_range(63) < 8)
			m_tready <= 1'b1;
		else if ($urandom_range(7) == 0)
			m_tready <= ~m_tready;
	end

	// Compare each output transfer with the oldest expected tree edge.
	always @(posedge clk) begin
		tree_edge_t want;
		tree_edge_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata[4:0], m_tdata[9:5], m_tdata[25:10], m_tuser, m_tlast};
			if (tree_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected tree edge %h", got);
			end else begin
				want = tree_q.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch: exp lo=%0d hi=%0d w=%0d r=%0d l=%0d",
							want.lo_v, want.hi_v, want.wt, want.reached, want.last);
						$display("          got lo=%0d hi=%0d w=%0d r=%0d l=%0d",
							got.lo_v, got.hi_v, got.wt, got.reached, got.last);
					end
				end
			end
		end
	end

	// Watchdog on cycles with no transfer on either side.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		m_tready = 1'b0;
		mismatches = 0;
		idle_cycles = 0;
		burst_left = 0;
		vcount = 6'd32;
		foreach (graph_w[i, j])
			graph_w[i][j] = '0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_vcount_extremes();
		test_random(6'd6, 80);
		test_random(6'd12, 80);
		test_random(6'd3, 60);
		test_random(6'd32, 60);
		test_random(6'd33, 20);
		drain();
		repeat (200) @(negedge clk);
		if (mismatches == 0 && tree_q.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// File: filelist.f
hdl/pmd_pkg.sv
hdl/pmd_ram.sv
hdl/pmd_cell.sv
hdl/prim_mst_dense_top.sv
tb/prim_mst_dense_top_tb.sv
